// ----- design/rtd_pkg.sv -----
`default_nettype none
package rtd_pkg;
  localparam int SensorCount = 3;
  localparam int NewtonSteps = 3;
  localparam logic [15:0] FaultCenti = 16'd9999;
  localparam logic signed [63:0] MapOffset = -64'sd22492743729;
  localparam logic signed [63:0] MapGain = 64'sd72799696;
  localparam logic signed [63:0] CoefA = 64'sd429496729600;
  localparam logic signed [63:0] CoefB = 64'sd1678602068;
  localparam logic signed [63:0] CoefC = -64'sd248034;
  localparam logic signed [63:0] CoefD = 64'sd180;
  localparam logic signed [63:0] CoefE = -64'sd2;
  localparam logic signed [63:0] Slope2C = -64'sd496069;
  localparam logic signed [63:0] TMax = 64'sd134217727;
  localparam logic signed [63:0] TMin = -64'sd134217728;
  localparam logic [2:0] RegDivisor = 3'd0;
  localparam logic [2:0] RegMaxTemp = 3'd1;
  localparam logic [2:0] RegOffset0 = 3'd2;
  localparam logic [2:0] RegOffset2 = 3'd4;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;     // capture item and start the average division
    logic map;      // average to ohms
    logic hmul;     // one Horner multiply
    logic hadd;     // shift and add coefficient
    logic smul;     // derivative product and Horner start
    logic dstart;   // start divider
    logic upd;      // apply Newton step
    logic fin;      // range check and store
  } rtd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic horner_last;
  } rtd_stat_t;
endpackage
`default_nettype wire

// ----- design/rtd_if.sv -----
`default_nettype none
interface rtd_in_if;
  logic valid;
  logic ready;
  logic [1:0] sensor_index;
  logic [15:0] raw_sample;
  modport source (output valid, sensor_index, raw_sample, input ready);
  modport sink (input valid, sensor_index, raw_sample, output ready);
endinterface

interface rtd_out_if;
  logic valid;
  logic ready;
  logic [1:0] sensor_echo;
  logic [15:0] filtered_counts;
  logic [15:0] temp_centi;
  logic sensor_fault;
  logic [15:0] bed_temp_centi;
  modport source (output valid, sensor_echo, filtered_counts, temp_centi, sensor_fault,
                  bed_temp_centi, input ready);
  modport sink (input valid, sensor_echo, filtered_counts, temp_centi, sensor_fault,
                bed_temp_centi, output ready);
endinterface

interface rtd_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/rtd_filter_and_linearizer.sv -----
// Pt100 filter and linearizer for SENSOR_COUNT channels (three by default).
// in: one request holds sensor_index and raw_sample. A request with a
// sensor_index of SENSOR_COUNT or more is taken and dropped with no result.
// out: one result per kept request: channel, new average, temperature in
// 0.01 deg (9999 and sensor_fault on range error) and the channel 0/1 mean.
// cfg: index/data writes to filter divisor, maximum and cable offsets, taken
// in any cycle; write only while no request is in flight.
// One request at a time: filter division and a mapping step, then per Newton
// step a slope product, a Horner multiply and add per coefficient (the CoefD
// and CoefE terms only for a negative estimate), a divider start and a wait
// on the bit-serial 64-bit divider, which sets the request rate.
// The result register holds while out.ready is low; no new request is taken
// until it is delivered.
// Reset clears averages, marks every channel for a first-sample load and sets
// stored temperatures to 9999; registers return to their defaults.
`default_nettype none
module rtd_filter_and_linearizer #(
  parameter int SENSOR_COUNT = rtd_pkg::SensorCount,
  parameter int NEWTON_STEPS = rtd_pkg::NewtonSteps
) (
  input wire logic clk,
  input wire logic rst_n,
  rtd_in_if.sink in_ch,
  rtd_out_if.source out_ch,
  rtd_cfg_if.sink cfg_ch
);
  rtd_pkg::rtd_cmd_t cmd;
  rtd_pkg::rtd_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  rtd_ctrl #(.SENSOR_COUNT(SENSOR_COUNT), .NEWTON_STEPS(NEWTON_STEPS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_idx(in_ch.sensor_index),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat));

  rtd_datapath #(.SENSOR_COUNT(SENSOR_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_idx(in_ch.sensor_index), .in_raw(in_ch.raw_sample),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_dat(cfg_ch.data),
    .o_echo(out_ch.sensor_echo), .o_avg(out_ch.filtered_counts),
    .o_temp(out_ch.temp_centi), .o_fault(out_ch.sensor_fault),
    .o_bed(out_ch.bed_temp_centi));
endmodule
`default_nettype wire

// ----- design/rtd_div.sv -----
`default_nettype none
// Signed 64/64 division, truncating, one quotient bit a cycle
module rtd_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [63:0] den,
  output logic done,
  output logic signed [63:0] quo
);
  logic [63:0] q_r, rem_r, d_r;
  logic neg_r, busy_r;
  logic [6:0] cnt_r;
  logic [64:0] trial;
  logic [63:0] rsh;

  always_comb begin
    rsh = {rem_r[62:0], q_r[63]};
    trial = {1'b0, rsh} - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd64;
        q_r <= num[63] ? -num : num;
        d_r <= den[63] ? -den : den;
        neg_r <= num[63] ^ den[63];
        rem_r <= '0;
      end else if (busy_r) begin
        if (!trial[64]) begin
          rem_r <= trial[63:0];
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= rsh;
          q_r <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire

// ----- design/rtd_datapath.sv -----
`default_nettype none
module rtd_datapath #(
  parameter int SENSOR_COUNT = rtd_pkg::SensorCount,
  localparam int IdxW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire rtd_pkg::rtd_cmd_t cmd,
  output rtd_pkg::rtd_stat_t stat,
  input  wire logic [1:0] in_idx,
  input  wire logic [15:0] in_raw,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [15:0] cfg_dat,
  output logic [1:0] o_echo,
  output logic [15:0] o_avg,
  output logic [15:0] o_temp,
  output logic o_fault,
  output logic [15:0] o_bed
);
  logic [6:0] div_r;
  logic [15:0] max_r;
  logic signed [15:0] off_r [3];
  logic [15:0] avg_r [SENSOR_COUNT];
  logic first_r [SENSOR_COUNT];
  logic [15:0] cur_r [SENSOR_COUNT];

  logic [1:0] ch_r;
  logic signed [63:0] r_r, t_r, y_r, p_r, s_r;
  logic [2:0] k_r;
  logic [22:0] wsum;
  logic [6:0] dd;
  logic [15:0] q16;
  logic dstart_r;
  logic signed [63:0] resid, quo, tn, v, lim, ck;
  logic ddone;

  // Filter divider: weighted sum, partial remainder, quotient and bits left
  logic [22:0] wsum_r;
  logic [22:0] frem_r;
  logic [15:0] fq_r;
  logic [4:0] fcnt_r;
  logic [22:0] ftr;

  function automatic logic signed [63:0] rtd_rnd(input logic signed [63:0] t);
    logic signed [63:0] pr;
    pr = rtd_pkg::Slope2C * t;
    return (pr >>> 16) + rtd_pkg::CoefB;
  endfunction

  function automatic logic [15:0] rtd_bed(input logic [1:0] ch, input logic signed [63:0] vv,
                                          input logic signed [63:0] lm);
    logic [16:0] a, b;
    logic [15:0] nt;
    nt = (vv < 0 || vv > lm) ? rtd_pkg::FaultCenti : vv[31:16];
    a = {1'b0, (ch == 2'd0) ? nt : cur_r[0]};
    b = (SENSOR_COUNT > 1) ? {1'b0, (ch == 2'd1) ? nt : cur_r[IdxW'(SENSOR_COUNT > 1)]}
                           : {1'b0, rtd_pkg::FaultCenti};
    return 16'((a + b) >> 1);
  endfunction

  always_comb begin
    dd = (div_r == 7'd0) ? 7'd1 : div_r;
    case (k_r)
      3'd0: ck = rtd_pkg::CoefA;
      3'd1: ck = rtd_pkg::CoefB;
      3'd2: ck = rtd_pkg::CoefC;
      3'd3: ck = rtd_pkg::CoefD;
      default: ck = rtd_pkg::CoefE;
    endcase
    resid = y_r - r_r;
    tn = t_r - quo;
    if (tn > rtd_pkg::TMax) tn = rtd_pkg::TMax;
    if (tn < rtd_pkg::TMin) tn = rtd_pkg::TMin;
    v = t_r * 64'sd100 + 64'($signed(ch_r < 2'd3 ? off_r[ch_r] : 16'sd0)) * 64'sd65536;
    lim = $signed({32'd0, max_r, 16'd0});
    wsum = 23'(dd - 7'd1) * 23'(avg_r[IdxW'(in_idx)]) + 23'(in_raw);
    ftr = {frem_r[21:0], wsum_r[5'(fcnt_r - 5'd1)]};
    q16 = fq_r;
  end

  assign stat.div_done = ddone;
  assign stat.horner_last = (k_r == 3'd0);

  rtd_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart_r), .num(resid <<< 16),
    .den(s_r), .done(ddone), .quo(quo));

  // Filter divide: divide the weighted sum a bit a cycle; first sample raw
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
    end else if (cmd.load) begin
      wsum_r <= wsum;
      frem_r <= '0;
      if (first_r[IdxW'(in_idx)]) begin
        fq_r <= in_raw;
        fcnt_r <= 5'd0;
      end else begin
        fq_r <= '0;
        fcnt_r <= 5'd23;
      end
    end else if (fcnt_r != 5'd0) begin
      if (ftr >= 23'(dd)) begin
        frem_r <= ftr - 23'(dd);
        fq_r <= {fq_r[14:0], 1'b1};
      end else begin
        frem_r <= ftr;
        fq_r <= {fq_r[14:0], 1'b0};
      end
      fcnt_r <= fcnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= 7'd8;
      max_r <= 16'd15000;
      for (int i = 0; i < 3; i++) off_r[i] <= '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        avg_r[i] <= '0;
        first_r[i] <= 1'b1;
        cur_r[i] <= rtd_pkg::FaultCenti;
      end
      dstart_r <= 1'b0;
    end else begin
      dstart_r <= cmd.dstart;
      if (cfg_we) begin
        if (cfg_idx == rtd_pkg::RegDivisor) div_r <= cfg_dat[6:0];
        else if (cfg_idx == rtd_pkg::RegMaxTemp) max_r <= cfg_dat;
        else if (cfg_idx >= rtd_pkg::RegOffset0 && cfg_idx <= rtd_pkg::RegOffset2)
          off_r[2'(cfg_idx - rtd_pkg::RegOffset0)] <= cfg_dat;
      end
      // load: capture channel, zero the estimate, clear first-sample mark
      if (cmd.load) begin
        ch_r <= in_idx;
        t_r <= '0;
        first_r[IdxW'(in_idx)] <= 1'b0;
      end
      if (cmd.map) begin
        avg_r[IdxW'(ch_r)] <= q16;
        o_avg <= q16;
        r_r <= rtd_pkg::MapOffset + rtd_pkg::MapGain * $signed({48'd0, q16});
      end
      // Horner step: the clamped estimate fits 28 bits and the partial sum
      // ahead of each multiply stays within 36 bits
      if (cmd.hmul) begin
        p_r <= $signed(y_r[35:0]) * $signed(t_r[27:0]);
      end
      if (cmd.hadd) begin
        y_r <= (p_r >>> 16) + ck;
        k_r <= k_r - 3'd1;
      end
      if (cmd.smul) begin
        s_r <= rtd_rnd(t_r);
        y_r <= (t_r < 0) ? rtd_pkg::CoefE : rtd_pkg::CoefC;
        k_r <= (t_r < 0) ? 3'd3 : 3'd1;
      end
      if (cmd.upd) t_r <= tn;
      if (cmd.fin) begin
        o_echo <= ch_r;
        if (v < 0 || v > lim) begin
          o_temp <= rtd_pkg::FaultCenti;
          o_fault <= 1'b1;
          cur_r[IdxW'(ch_r)] <= rtd_pkg::FaultCenti;
        end else begin
          o_temp <= v[31:16];
          o_fault <= 1'b0;
          cur_r[IdxW'(ch_r)] <= v[31:16];
        end
      end
      if (cmd.fin) o_bed <= rtd_bed(ch_r, v, lim);
    end
  end
endmodule
`default_nettype wire

// ----- design/rtd_ctrl.sv -----
`default_nettype none
module rtd_ctrl #(
  parameter int SENSOR_COUNT = rtd_pkg::SensorCount,
  parameter int NEWTON_STEPS = rtd_pkg::NewtonSteps
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic [1:0] in_idx,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output rtd_pkg::rtd_cmd_t cmd,
  input  wire rtd_pkg::rtd_stat_t stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_FILT, S_MAP, S_SMUL, S_HMUL, S_HADD, S_DIV, S_WAIT, S_FIN, S_OUT
  } state_t;
  state_t st_r;
  logic [4:0] cnt_r;
  logic [3:0] step_r;
  logic acc;

  assign in_ready = (st_r == S_IDLE);
  assign acc = in_valid && in_ready && (32'(in_idx) < SENSOR_COUNT);

  always_comb begin
    cmd = '0;
    cmd.load = acc;
    cmd.map = (st_r == S_MAP);
    cmd.smul = (st_r == S_SMUL);
    cmd.hmul = (st_r == S_HMUL);
    cmd.hadd = (st_r == S_HADD);
    cmd.dstart = (st_r == S_DIV);
    cmd.upd = (st_r == S_WAIT) && stat.div_done;
    cmd.fin = (st_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (acc) begin
          st_r <= S_FILT;
          cnt_r <= 5'd24;
        end
        S_FILT: begin
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) st_r <= S_MAP;
        end
        S_MAP: begin
          st_r <= S_SMUL;
          step_r <= '0;
        end
        S_SMUL: st_r <= S_HMUL;
        S_HMUL: st_r <= S_HADD;
        S_HADD: st_r <= stat.horner_last ? S_DIV : S_HMUL;
        S_DIV: st_r <= S_WAIT;
        S_WAIT: if (stat.div_done) begin
          step_r <= step_r + 4'd1;
          st_r <= (32'(step_r) + 1 == NEWTON_STEPS) ? S_FIN : S_SMUL;
        end
        S_FIN: begin
          st_r <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/tb_rtd_filter_and_linearizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_rtd_filter_and_linearizer;

  typedef struct packed {
    logic [1:0]  sensor;
    logic [15:0] counts;
    logic [15:0] temp;
    logic        fault;
    logic [15:0] bed;
  } rtd_result_t;

  localparam longint CycleLimit = 3000000;
  localparam int DrainCycles = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rtd_in_if in_ch ();
  rtd_out_if out_ch ();
  rtd_cfg_if cfg_ch ();

  rtd_filter_and_linearizer u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [6:0]         pr_divisor;
  logic [15:0]        pr_max_temp;
  logic signed [15:0] pr_offset [3];
  logic [15:0]        pr_average [3];
  logic               pr_first [3];
  logic [15:0]        pr_temp [3];

  rtd_result_t expected_results[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_off = 0;
  longint cycles = 0;

  function automatic longint floor_shr16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint its_poly(longint t);
    longint y;
    y = (t < 0) ? rtd_pkg::CoefE : rtd_pkg::CoefC;
    if (t < 0) begin
      y = floor_shr16(y * t) + rtd_pkg::CoefD;
      y = floor_shr16(y * t) + rtd_pkg::CoefC;
    end
    y = floor_shr16(y * t) + rtd_pkg::CoefB;
    y = floor_shr16(y * t) + rtd_pkg::CoefA;
    return y;
  endfunction

  function automatic longint invert_its(longint r);
    longint t;
    longint slope;
    t = 0;
    for (int s = 0; s < rtd_pkg::NewtonSteps; s++) begin
      slope = floor_shr16(rtd_pkg::Slope2C * t) + rtd_pkg::CoefB;
      t = t - ((its_poly(t) - r) * 65536) / slope;
      if (t > rtd_pkg::TMax) t = rtd_pkg::TMax;
      if (t < rtd_pkg::TMin) t = rtd_pkg::TMin;
    end
    return t;
  endfunction

  // Work out the result of one request and update predictor state
  function automatic void predict_temperature(logic [1:0] ch, logic [15:0] raw);
    rtd_result_t res;
    longint d, avg, t, v;
    if (ch >= rtd_pkg::SensorCount) return;
    if (pr_first[ch]) begin
      avg = raw;
      pr_first[ch] = 1'b0;
    end else begin
      d = (pr_divisor == 0) ? 1 : pr_divisor;
      avg = ((d - 1) * pr_average[ch] + raw) / d;
    end
    pr_average[ch] = avg[15:0];
    t = invert_its(rtd_pkg::MapOffset + rtd_pkg::MapGain * avg);
    v = t * 100 + longint'(pr_offset[ch]) * 65536;
    if (v < 0 || v > longint'(pr_max_temp) * 65536) begin
      res.temp = rtd_pkg::FaultCenti;
      res.fault = 1'b1;
    end else begin
      res.temp = 16'(v / 65536);
      res.fault = 1'b0;
    end
    pr_temp[ch] = res.temp;
    res.sensor = ch;
    res.counts = avg[15:0];
    res.bed = 16'((32'(pr_temp[0]) + 32'(pr_temp[1])) / 2);
    expected_results.push_back(res);
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("rtd_filter_and_linearizer regression: fail");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each delivered result
  always @(posedge clk) begin
    rtd_result_t got, exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.sensor_echo, out_ch.filtered_counts, out_ch.temp_centi,
              out_ch.sensor_fault, out_ch.bed_temp_centi};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (got.sensor !== exp_res.sensor)
          $display("%0t: sensor_echo exp %0d got %0d", $time, exp_res.sensor, got.sensor);
        if (got.counts !== exp_res.counts)
          $display("%0t: filtered_counts exp %0d got %0d", $time, exp_res.counts, got.counts);
        if (got.temp !== exp_res.temp)
          $display("%0t: temp_centi exp %0d got %0d", $time, exp_res.temp, got.temp);
        if (got.fault !== exp_res.fault)
          $display("%0t: sensor_fault exp %0d got %0d", $time, exp_res.fault, got.fault);
        if (got.bed !== exp_res.bed)
          $display("%0t: bed_temp_centi exp %0d got %0d", $time, exp_res.bed, got.bed);
        if (got !== exp_res) errors++;
      end
    end
  end

  // Offer one request; valid stays up after acceptance until the next
  // request replaces it or the sender idles or drains
  task automatic send_sample(logic [1:0] ch, logic [15:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sensor_index <= ch;
    in_ch.raw_sample <= raw;
    do @(posedge clk); while (!in_ch.ready);
    predict_temperature(ch, raw);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write; only called while the block is idle
  task automatic write_register(logic [2:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      rtd_pkg::RegDivisor: pr_divisor = data[6:0];
      rtd_pkg::RegMaxTemp: pr_max_temp = data;
      default: if (idx >= rtd_pkg::RegOffset0 && idx <= rtd_pkg::RegOffset2)
                 pr_offset[idx - rtd_pkg::RegOffset0] = data;
    endcase
    @(posedge clk);
  endtask

  task automatic set_registers(logic [6:0] d, logic [15:0] mx, logic [15:0] o0,
                               logic [15:0] o1, logic [15:0] o2);
    drain_results();
    write_register(rtd_pkg::RegDivisor, 16'(d));
    write_register(rtd_pkg::RegMaxTemp, mx);
    write_register(rtd_pkg::RegOffset0, o0);
    write_register(rtd_pkg::RegOffset0 + 3'd1, o1);
    write_register(rtd_pkg::RegOffset2, o2);
  endtask

  // Field extremes, first-sample load, fault, ignored channel, unknown register
  task automatic test_directed();
    send_sample(2'd0, 16'd0);
    send_sample(2'd1, 16'hFFFF);
    send_sample(2'd2, 16'd309);
    send_sample(2'd3, 16'h5555);
    send_sample(2'd0, 16'hFFFF);
    send_sample(2'd1, 16'd0);
    send_sample(2'd2, 16'hAAAA);
    set_registers(7'd0, 16'd50000, 16'h7FFF, 16'h8000, 16'd0);
    write_register(3'd5, 16'hFFFF);
    write_register(3'd7, 16'h1234);
    send_sample(2'd0, 16'd500);
    send_sample(2'd1, 16'd1000);
    send_sample(2'd2, 16'd2000);
    send_sample(2'd3, 16'd0);
    set_registers(7'd64, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(2'd0, 16'd400);
    send_sample(2'd1, 16'd40000);
    set_registers(7'd127, 16'hFFFF, 16'hFF00, 16'd100, 16'hFFFF);
    send_sample(2'd2, 16'd800);
    send_sample(2'd0, 16'd12345);
  endtask

  // Mostly plausible readings with occasional full-range noise
  task automatic test_random(int count);
    logic [15:0] raw;
    logic [1:0]  ch;
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      raw = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000, 200));
      send_sample(ch, raw);
    end
  endtask

  // Receiver holds off while requests keep coming, then sender waits for all
  task automatic test_backpressure();
    hold_off = 1500;
    test_random(12);
    drain_results();
    test_random(8);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sensor_index = '0;
    in_ch.raw_sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    pr_divisor = 7'd8;
    pr_max_temp = 16'd15000;
    for (int i = 0; i < 3; i++) begin
      pr_offset[i] = '0;
      pr_average[i] = '0;
      pr_first[i] = 1'b1;
      pr_temp[i] = rtd_pkg::FaultCenti;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 11;
    recv_idle_pct = 45;
    test_directed();
    set_registers(7'd8, 16'd15000, 16'd0, 16'd0, 16'd0);
    test_random(350);
    set_registers(7'd1, 16'd50000, 16'hFF9C, 16'd250, 16'd0);
    send_idle_pct = 45;
    recv_idle_pct = 11;
    test_random(350);
    test_backpressure();
    set_registers(7'd3, 16'd12000, 16'd0, 16'hFE0C, 16'd1000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350);
    drain_results();
    if (errors == 0) begin
      $display("rtd_filter_and_linearizer regression: pass");
    end else begin
      $display("rtd_filter_and_linearizer regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
